// ===== rtl/tes_pkg.sv =====
package tes_pkg;

    localparam int ELECTRODES_DEFAULT = 16;

    localparam int ELEC_W      = 4;
    localparam int COUNT_W     = 4;
    localparam int VOLT_W      = 16;
    localparam int MODE_W      = 3;
    localparam int DIR_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [MODE_W-1:0] MODE_STANDBY      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CALIBRATE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADJACENT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PSEUDO_POLAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLAR_POLAR  = 3'd4;

    localparam logic [DIR_W-1:0] DIR_INC  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DEC  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_HOLD = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_DIR   = 2'd1;

    typedef struct packed {
        logic [ELEC_W-1:0]  source;
        logic [ELEC_W-1:0]  sink;
        logic [ELEC_W-1:0]  plus;
        logic [ELEC_W-1:0]  minus;
        logic [COUNT_W-1:0] count;
    } tes_state_t;

    // Packed so that voltage sits in the lowest bits of tdata.
    typedef struct packed {
        logic [2*ELEC_W-1:0] sense_mux;
        logic [2*ELEC_W-1:0] drive_mux;
        logic [ELEC_W-1:0]   minus;
        logic [ELEC_W-1:0]   plus;
        logic [ELEC_W-1:0]   sink;
        logic [ELEC_W-1:0]   source;
        logic [VOLT_W-1:0]   voltage;
    } tes_data_t;

    typedef struct packed {
        logic      cycle_last;
        logic      frame_start;
        logic      cycle_first;
        tes_data_t data;
    } tes_result_t;

    localparam int DATA_W   = $bits(tes_data_t);
    localparam int RESULT_W = $bits(tes_result_t);

    function automatic logic mode_active(logic [MODE_W-1:0] mode);
        return mode inside {MODE_CALIBRATE, MODE_ADJACENT, MODE_PSEUDO_POLAR,
                            MODE_POLAR_POLAR};
    endfunction

    // One electrode step; last is the highest electrode number in use.
    function automatic logic [ELEC_W-1:0] step_elec(logic [ELEC_W-1:0] v,
                                                    logic [DIR_W-1:0]  dir,
                                                    logic [ELEC_W-1:0] last);
        logic [ELEC_W-1:0] r;
        case (dir)
            DIR_INC: r = (v >= last) ? '0 : v + 1'b1;
            DIR_DEC: r = (v == '0 || v > last) ? last : v - 1'b1;
            default: r = v;
        endcase
        return r;
    endfunction

    // Start electrodes of a mode; standby codes keep the electrodes.
    function automatic tes_state_t load_start(tes_state_t s,
                                              logic [MODE_W-1:0] mode,
                                              logic [ELEC_W-1:0] polar_sink);
        tes_state_t r;
        r       = s;
        r.count = '0;
        case (mode)
            MODE_CALIBRATE, MODE_ADJACENT:
            begin
                r.source = ELEC_W'(1);
                r.sink   = '0;
                r.plus   = '0;
                r.minus  = ELEC_W'(1);
            end
            MODE_PSEUDO_POLAR:
            begin
                r.source = '0;
                r.sink   = polar_sink;
                r.plus   = '0;
                r.minus  = ELEC_W'(1);
            end
            MODE_POLAR_POLAR:
            begin
                r.source = '0;
                r.sink   = polar_sink;
                r.plus   = '0;
                r.minus  = polar_sink;
            end
            default: r.count = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tes_step.sv =====
module tes_step #(
    parameter int ELECTRODES = tes_pkg::ELECTRODES_DEFAULT
) (
    input  tes_pkg::tes_state_t                 state_cur,
    input  logic [tes_pkg::MODE_W-1:0]          mode,
    input  logic [tes_pkg::DIR_W-1:0]           dir,
    input  logic                                restart,
    input  logic [tes_pkg::VOLT_W-1:0]          voltage,
    output tes_pkg::tes_state_t                 state_next,
    output tes_pkg::tes_result_t                result
);

    localparam logic [tes_pkg::ELEC_W-1:0] LAST_ELEC  = tes_pkg::ELEC_W'(ELECTRODES - 1);
    localparam logic [tes_pkg::ELEC_W-1:0] POLAR_SINK = tes_pkg::ELEC_W'(ELECTRODES / 2 - 1);

    tes_pkg::tes_state_t s0;
    tes_pkg::tes_state_t nxt;
    logic                first;
    logic                last;
    logic                drive_step;

    always_comb
    begin
        s0 = restart ? tes_pkg::load_start(state_cur, mode, POLAR_SINK) : state_cur;

        first = (s0.count == '0);
        // The count is narrow enough to exceed the last position only with
        // fewer than sixteen electrodes, hence a compare rather than equality.
        last  = (s0.count >= tes_pkg::COUNT_W'(ELECTRODES - 1));

        nxt       = s0;
        nxt.plus  = tes_pkg::step_elec(s0.plus, dir, LAST_ELEC);
        nxt.minus = tes_pkg::step_elec(s0.minus, dir, LAST_ELEC);

        drive_step = (mode == tes_pkg::MODE_CALIBRATE) ||
                     (last && mode == tes_pkg::MODE_ADJACENT);
        if (drive_step)
        begin
            nxt.sink   = tes_pkg::step_elec(s0.sink, dir, LAST_ELEC);
            nxt.source = tes_pkg::step_elec(s0.source, dir, LAST_ELEC);
        end
        nxt.count = last ? '0 : s0.count + 1'b1;

        result.data.voltage   = voltage;
        result.data.source    = s0.source;
        result.data.sink      = s0.sink;
        result.data.plus      = s0.plus;
        result.data.minus     = s0.minus;
        result.data.drive_mux = {nxt.sink, nxt.source};
        result.data.sense_mux = {nxt.minus, nxt.plus};
        result.cycle_first    = first;
        result.frame_start    = first && (s0.sink == '0);
        result.cycle_last     = last;

        state_next = nxt;
    end

endmodule

// ===== rtl/tes_skid.sv =====
module tes_skid #(
    parameter int WIDTH = tes_pkg::RESULT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             main_valid_reg;
    logic [WIDTH-1:0] main_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !main_valid_reg)
        begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            // Output stalled with a beat already held: park the new one.
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !main_valid_reg)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/tomography_electrode_sequencer.sv =====
// Electrode drive sequencer: tags each sample beat with its electrodes.
// The result of an accepted input beat is registered in the output buffer.
// Throughput: one beat per cycle while the output buffer is not full; the electrode
// update and the tag logic are combinational, and a two-entry output buffer absorbs stalls.
// Reset (rst_n, asynchronous, active low): adjacent mode, increment, start
// electrodes source 1, sink 0, plus 0, minus 1, output buffer empty.
module tomography_electrode_sequencer #(
    parameter int ELECTRODES = tes_pkg::ELECTRODES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tes_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tes_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // sample_voltage
    input  logic [0:0]                         s_axis_tuser,  // restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // voltage_out, source_electrode, sink_electrode, plus_electrode,
    // minus_electrode, drive_mux_byte, sense_mux_byte
    output logic [47:0]                        m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,  // cycle_first, frame_start
    output logic                               m_axis_tlast   // cycle_last
);

    localparam logic [tes_pkg::ELEC_W-1:0] POLAR_SINK = tes_pkg::ELEC_W'(ELECTRODES / 2 - 1);

    logic [tes_pkg::MODE_W-1:0] mode_reg;
    logic [tes_pkg::DIR_W-1:0]  dir_reg;
    tes_pkg::tes_state_t        state_reg;
    tes_pkg::tes_state_t        state_next;
    tes_pkg::tes_result_t       step_result;
    tes_pkg::tes_result_t       out_result;
    logic                       in_fire;
    logic                       active;
    logic                       buf_ready;

    assign active        = tes_pkg::mode_active(mode_reg);
    assign s_axis_tready = buf_ready;
    assign in_fire       = s_axis_tvalid && buf_ready;

    tes_step #(
        .ELECTRODES (ELECTRODES)
    ) u_step (
        .state_cur  (state_reg),
        .mode       (mode_reg),
        .dir        (dir_reg),
        .restart    (s_axis_tuser[0]),
        .voltage    (s_axis_tdata),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tes_pkg::MODE_ADJACENT;
            dir_reg         <= tes_pkg::DIR_INC;
            state_reg.source <= tes_pkg::ELEC_W'(1);
            state_reg.sink   <= '0;
            state_reg.plus   <= '0;
            state_reg.minus  <= tes_pkg::ELEC_W'(1);
            state_reg.count  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tes_pkg::REG_DRIVE_MODE:
                begin
                    mode_reg  <= cfg_data;
                    state_reg <= tes_pkg::load_start(state_reg, cfg_data, POLAR_SINK);
                end
                tes_pkg::REG_STEP_DIR:
                begin
                    dir_reg <= cfg_data[tes_pkg::DIR_W-1:0];
                end
                default:
                begin
                    dir_reg <= dir_reg;
                end
            endcase
        end
        else if (in_fire && active)
        begin
            state_reg <= state_next;
        end
    end

    // Standby beats are taken and dropped without a result.
    tes_skid #(
        .WIDTH (tes_pkg::RESULT_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_fire && active),
        .in_ready  (buf_ready),
        .in_data   (step_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = out_result.data;
    assign m_axis_tuser = {out_result.frame_start, out_result.cycle_first};
    assign m_axis_tlast = out_result.cycle_last;

endmodule
